// ===== rtl/core/ppp_pkg.sv =====
// Package with the register codes, reset values and payload types of the point projection.
package ppp_pkg;

  localparam int ADDR_WIDTH = 6;
  localparam int DATA_WIDTH = 64;
  localparam int REG_IDX_WIDTH = 3;
  localparam int PIX_WIDTH = 16;
  localparam int COORD_WIDTH = 16;

  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_ROW_0 = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_ROW_1 = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_ROW_2 = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_TRANSLATION = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FOCAL_X = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FOCAL_Y = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_X = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Y = 3'd7;

  localparam logic [47:0] ROT_ROW_0_RESET = 48'd16384;
  localparam logic [47:0] ROT_ROW_1_RESET = 48'd1073741824;
  localparam logic [47:0] ROT_ROW_2_RESET = 48'd70368744177664;
  localparam logic [47:0] TRANSLATION_RESET = 48'd0;
  localparam logic [11:0] FOCAL_X_RESET = 12'd400;
  localparam logic [11:0] FOCAL_Y_RESET = 12'd400;
  localparam logic [11:0] CENTER_X_RESET = 12'd190;
  localparam logic [11:0] CENTER_Y_RESET = 12'd160;

  localparam logic [PIX_WIDTH-1:0] PIX_MAX = 16'h7fff;
  localparam logic [PIX_WIDTH-1:0] PIX_MIN = 16'h8000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] world_x;
    logic signed [COORD_WIDTH-1:0] world_y;
    logic signed [COORD_WIDTH-1:0] world_z;
  } point_t;

  typedef struct packed {
    logic signed [PIX_WIDTH-1:0] pixel_v;
    logic signed [PIX_WIDTH-1:0] pixel_u;
  } pixel_t;

endpackage

// ===== rtl/core/pinhole_point_projection.sv =====
// Pinhole point projection: camera transform, depth test and pipelined projection divide.
// Product, sum, multiply and numerator stages feed a 16-stage restoring divider.
// Accepts one point per cycle unless the output queue is full; the divider sets the depth.
// A two-entry output queue lets the pipeline run while one result waits to be taken.
// Points with camera depth at or below zero leave no result.
// Synchronous reset restores the registers to their reset values and empties the pipeline.
module pinhole_point_projection #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ppp_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ppp_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ppp_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ppp_pkg::point_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ppp_pkg::pixel_t                      out_data
);

  localparam int PW = ppp_pkg::COORD_WIDTH + 16;
  localparam int SUMW = ppp_pkg::COORD_WIDTH + 18;
  localparam int TRW = COORD_FRAC_BITS + 22;
  localparam int CAMW = ((SUMW > TRW) ? SUMW : TRW) + 1;
  localparam int HW = CAMW - 24;
  localparam int NUMW = CAMW + 14;
  localparam int DW = CAMW + 16;
  localparam int ZW = CAMW - 1;
  localparam int ND = 16;

  logic [47:0] rot [0:2];
  logic [47:0] trans;
  logic [11:0] focal_x;
  logic [11:0] focal_y;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [ppp_pkg::REG_IDX_WIDTH-1:0] reg_idx;
  logic cfg_write;

  assign pready = 1'b1;
  assign reg_idx = paddr[ppp_pkg::ADDR_WIDTH-1:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ppp_pkg::ROT_ROW_0_RESET;
      rot[1] <= ppp_pkg::ROT_ROW_1_RESET;
      rot[2] <= ppp_pkg::ROT_ROW_2_RESET;
      trans <= ppp_pkg::TRANSLATION_RESET;
      focal_x <= ppp_pkg::FOCAL_X_RESET;
      focal_y <= ppp_pkg::FOCAL_Y_RESET;
      center_x <= ppp_pkg::CENTER_X_RESET;
      center_y <= ppp_pkg::CENTER_Y_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ppp_pkg::REG_ROT_ROW_0: rot[0] <= pwdata[47:0];
        ppp_pkg::REG_ROT_ROW_1: rot[1] <= pwdata[47:0];
        ppp_pkg::REG_ROT_ROW_2: rot[2] <= pwdata[47:0];
        ppp_pkg::REG_TRANSLATION: trans <= pwdata[47:0];
        ppp_pkg::REG_FOCAL_X: focal_x <= pwdata[11:0];
        ppp_pkg::REG_FOCAL_Y: focal_y <= pwdata[11:0];
        ppp_pkg::REG_CENTER_X: center_x <= pwdata[11:0];
        ppp_pkg::REG_CENTER_Y: center_y <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppp_pkg::REG_ROT_ROW_0: prdata = {16'd0, rot[0]};
      ppp_pkg::REG_ROT_ROW_1: prdata = {16'd0, rot[1]};
      ppp_pkg::REG_ROT_ROW_2: prdata = {16'd0, rot[2]};
      ppp_pkg::REG_TRANSLATION: prdata = {16'd0, trans};
      ppp_pkg::REG_FOCAL_X: prdata = {52'd0, focal_x};
      ppp_pkg::REG_FOCAL_Y: prdata = {52'd0, focal_y};
      ppp_pkg::REG_CENTER_X: prdata = {52'd0, center_x};
      ppp_pkg::REG_CENTER_Y: prdata = {52'd0, center_y};
      default: prdata = '0;
    endcase
  end

  logic [1:0] count;
  logic advance;
  logic push;
  logic pop;

  assign advance = (count != 2'd2);
  assign in_stall = !advance;

  logic signed [CAMW-1:0] tr_term [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_trans
    logic signed [15:0] tr;
    logic signed [CAMW-1:0] tr_al;
    assign tr = trans[16*a +: 16];
    if (COORD_FRAC_BITS >= 8) begin : g_up
      assign tr_al = CAMW'(tr) <<< (COORD_FRAC_BITS - 8);
    end else begin : g_down
      assign tr_al = CAMW'(tr) >>> (8 - COORD_FRAC_BITS);
    end
    assign tr_term[a] = tr_al <<< 14;
  end

  logic signed [ppp_pkg::COORD_WIDTH-1:0] w_in [0:2];
  assign w_in[0] = in_data.world_x;
  assign w_in[1] = in_data.world_y;
  assign w_in[2] = in_data.world_z;

  logic v1;
  logic signed [PW-1:0] prod1 [0:2][0:2];
  logic signed [CAMW-1:0] tr1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [15:0] re;
      assign re = rot[r][16*c +: 16];
      always_ff @(posedge clk) begin
        if (advance) begin
          prod1[r][c] <= re * w_in[c];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        tr1[r] <= tr_term[r];
      end
    end
  end

  logic v2;
  logic signed [CAMW-1:0] cam2 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_sum
    always_ff @(posedge clk) begin
      if (advance) begin
        cam2[r] <= CAMW'(prod1[r][0]) + CAMW'(prod1[r][1]) + CAMW'(prod1[r][2]) + tr1[r];
      end
    end
  end

  logic v3;
  logic zpos3;
  logic [ZW-1:0] zc3;
  logic [35:0] fu_lo3, fv_lo3, cu_lo3, cv_lo3;
  logic signed [HW+12:0] fu_hi3, fv_hi3, cu_hi3, cv_hi3;
  logic signed [12:0] fx_s, fy_s, cx_s, cy_s;
  logic signed [HW-1:0] xh2, yh2, zh2;

  assign fx_s = $signed({1'b0, focal_x});
  assign fy_s = $signed({1'b0, focal_y});
  assign cx_s = $signed({1'b0, center_x});
  assign cy_s = $signed({1'b0, center_y});
  assign xh2 = cam2[0][CAMW-1:24];
  assign yh2 = cam2[1][CAMW-1:24];
  assign zh2 = cam2[2][CAMW-1:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zpos3 <= !cam2[2][CAMW-1] && (cam2[2] != '0);
      zc3 <= cam2[2][ZW-1:0];
      fu_lo3 <= focal_x * cam2[0][23:0];
      fv_lo3 <= focal_y * cam2[1][23:0];
      cu_lo3 <= center_x * cam2[2][23:0];
      cv_lo3 <= center_y * cam2[2][23:0];
      fu_hi3 <= fx_s * xh2;
      fv_hi3 <= fy_s * yh2;
      cu_hi3 <= cx_s * zh2;
      cv_hi3 <= cy_s * zh2;
    end
  end

  logic v4;
  logic [ZW-1:0] zc4;
  logic signed [NUMW-1:0] num_u4, num_v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3 && zpos3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zc4 <= zc3;
      num_u4 <= (NUMW'(fu_hi3) <<< 24) + NUMW'($signed({1'b0, fu_lo3}))
              + (NUMW'(cu_hi3) <<< 24) + NUMW'($signed({1'b0, cu_lo3}));
      num_v4 <= (NUMW'(fv_hi3) <<< 24) + NUMW'($signed({1'b0, fv_lo3}))
              + (NUMW'(cv_hi3) <<< 24) + NUMW'($signed({1'b0, cv_lo3}));
    end
  end

  logic vd [0:ND];
  logic [DW-1:0] rem_u [0:ND];
  logic [DW-1:0] rem_v [0:ND];
  logic [15:0] q_u [0:ND];
  logic [15:0] q_v [0:ND];
  logic neg_u [0:ND];
  logic neg_v [0:ND];
  logic ovf_u [0:ND];
  logic ovf_v [0:ND];
  logic [ZW-1:0] zc_d [0:ND];
  logic [DW-1:0] mag_u4, mag_v4, zlim4;

  assign mag_u4 = num_u4[NUMW-1] ? DW'(-num_u4) : DW'(num_u4);
  assign mag_v4 = num_v4[NUMW-1] ? DW'(-num_v4) : DW'(num_v4);
  assign zlim4 = DW'(zc4) << 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (advance) begin
      vd[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_u[0] <= mag_u4;
      rem_v[0] <= mag_v4;
      q_u[0] <= '0;
      q_v[0] <= '0;
      neg_u[0] <= num_u4[NUMW-1];
      neg_v[0] <= num_v4[NUMW-1];
      ovf_u[0] <= (mag_u4 >= zlim4);
      ovf_v[0] <= (mag_v4 >= zlim4);
      zc_d[0] <= zc4;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int K = ND - 1 - j;
    logic [DW:0] dsh;
    logic [DW:0] tu, tv;
    assign dsh = (DW + 1)'(zc_d[j]) << K;
    assign tu = {1'b0, rem_u[j]} - dsh;
    assign tv = {1'b0, rem_v[j]} - dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (advance) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_u[j+1] <= tu[DW] ? rem_u[j] : tu[DW-1:0];
        rem_v[j+1] <= tv[DW] ? rem_v[j] : tv[DW-1:0];
        q_u[j+1] <= q_u[j] | (16'(!tu[DW]) << K);
        q_v[j+1] <= q_v[j] | (16'(!tv[DW]) << K);
        neg_u[j+1] <= neg_u[j];
        neg_v[j+1] <= neg_v[j];
        ovf_u[j+1] <= ovf_u[j];
        ovf_v[j+1] <= ovf_v[j];
        zc_d[j+1] <= zc_d[j];
      end
    end
  end

  function automatic logic [15:0] saturate(input logic neg, input logic ovf,
                                           input logic [15:0] q);
    logic [15:0] res;
    if (!neg) begin
      res = (ovf || q[15]) ? ppp_pkg::PIX_MAX : q;
    end else begin
      res = (ovf || (q > ppp_pkg::PIX_MIN)) ? ppp_pkg::PIX_MIN : (16'd0 - q);
    end
    return res;
  endfunction

  ppp_pkg::pixel_t res_new;
  ppp_pkg::pixel_t buf0;
  ppp_pkg::pixel_t buf1;

  assign res_new.pixel_u = saturate(neg_u[ND], ovf_u[ND], q_u[ND]);
  assign res_new.pixel_v = saturate(neg_v[ND], ovf_v[ND], q_v[ND]);

  assign push = advance && vd[ND];
  assign pop = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign out_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (count == 2'd1)) begin
        buf0 <= res_new;
      end else begin
        buf0 <= buf1;
        if (push) begin
          buf1 <= res_new;
        end
      end
    end else if (push) begin
      if (count == 2'd0) begin
        buf0 <= res_new;
      end else begin
        buf1 <= res_new;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue count out of range");
  assert property (@(posedge clk) disable iff (rst) !(vd[ND] && advance && count == 2'd2))
    else $error("result pushed into a full output queue");
  assert property (@(posedge clk) $past(rst) |-> (count == 2'd0 && !v1 && !vd[ND]))
    else $error("pipeline not empty after reset");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !push)
    else $error("pipeline advanced while the output queue was full");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the pinhole point projection: directed and random points checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    ppp_pkg::point_t pt;
    bit check_fixed;
    bit kept;
    logic [15:0] u;
    logic [15:0] v;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ppp_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [ppp_pkg::DATA_WIDTH-1:0] pwdata = '0;
  logic [ppp_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  ppp_pkg::point_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ppp_pkg::pixel_t out_data;

  logic [47:0] rot_row [3];
  logic [47:0] trans_reg;
  logic [11:0] fx_reg, fy_reg, cx_reg, cy_reg;

  ppp_pkg::pixel_t pixel_queue[$];
  int errors = 0;
  int points_sent = 0;
  int pixels_seen = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  pinhole_point_projection uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [15:0] lane(logic [47:0] packed_val, int idx);
    return packed_val[16*idx +: 16];
  endfunction

  function automatic logic signed [63:0] camera_axis(int axis, ppp_pkg::point_t p);
    logic signed [63:0] acc;
    acc = lane(rot_row[axis], 0) * 64'(p.world_x) + lane(rot_row[axis], 1) * 64'(p.world_y)
        + lane(rot_row[axis], 2) * 64'(p.world_z);
    acc += 64'(lane(trans_reg, axis)) * 64'sd16384;
    return acc;
  endfunction

  function automatic logic [15:0] pixel_coord(logic signed [63:0] c,
      logic signed [63:0] depth, logic [11:0] focal, logic [11:0] center);
    logic signed [63:0] num, q;
    num = $signed({52'd0, focal}) * c + $signed({52'd0, center}) * depth;
    q = num / depth;
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    return q[15:0];
  endfunction

  function automatic bit project_point(ppp_pkg::point_t p, output ppp_pkg::pixel_t px);
    logic signed [63:0] xc, yc, zc;
    xc = camera_axis(0, p);
    yc = camera_axis(1, p);
    zc = camera_axis(2, p);
    px = '0;
    if (zc <= 0) return 0;
    px.pixel_u = pixel_coord(xc, zc, fx_reg, cx_reg);
    px.pixel_v = pixel_coord(yc, zc, fy_reg, cy_reg);
    return 1;
  endfunction

  task automatic write_reg(logic [ppp_pkg::REG_IDX_WIDTH-1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ppp_pkg::ADDR_WIDTH'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ppp_pkg::REG_ROT_ROW_0: rot_row[0] = value[47:0];
      ppp_pkg::REG_ROT_ROW_1: rot_row[1] = value[47:0];
      ppp_pkg::REG_ROT_ROW_2: rot_row[2] = value[47:0];
      ppp_pkg::REG_TRANSLATION: trans_reg = value[47:0];
      ppp_pkg::REG_FOCAL_X: fx_reg = value[11:0];
      ppp_pkg::REG_FOCAL_Y: fy_reg = value[11:0];
      ppp_pkg::REG_CENTER_X: cx_reg = value[11:0];
      default: cy_reg = value[11:0];
    endcase
  endtask

  task automatic send_point(ppp_pkg::point_t p);
    ppp_pkg::pixel_t px;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (project_point(p, px)) pixel_queue.push_back(px);
    points_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (pixel_queue.size() != 0) begin
      $display("simulation failed");
      $finish;
    end
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    ppp_pkg::pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel u=%0d v=%0d", out_data.pixel_u, out_data.pixel_v);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_data.pixel_u !== want.pixel_u) begin
          $error("pixel_u expected %0d actual %0d", want.pixel_u, out_data.pixel_u);
          errors++;
        end
        if (out_data.pixel_v !== want.pixel_v) begin
          $error("pixel_v expected %0d actual %0d", want.pixel_v, out_data.pixel_v);
          errors++;
        end
      end
    end
  end

  function automatic logic [47:0] rand_rot();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  initial begin
    dir_row_t rows[$];
    ppp_pkg::point_t p;
    ppp_pkg::pixel_t px;
    int phase;
    rot_row[0] = ppp_pkg::ROT_ROW_0_RESET;
    rot_row[1] = ppp_pkg::ROT_ROW_1_RESET;
    rot_row[2] = ppp_pkg::ROT_ROW_2_RESET;
    trans_reg = ppp_pkg::TRANSLATION_RESET;
    fx_reg = ppp_pkg::FOCAL_X_RESET;
    fy_reg = ppp_pkg::FOCAL_Y_RESET;
    cx_reg = ppp_pkg::CENTER_X_RESET;
    cy_reg = ppp_pkg::CENTER_Y_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At reset the point on the axis lands on the principal point.
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd256}, 1, 1, 16'd190, 16'd160});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1, 0, 16'd0, 16'd0});
    rows.push_back('{'{16'sd5, 16'sd5, -16'sd256}, 1, 0, 16'd0, 16'd0});
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sd1}, 1, 1, ppp_pkg::PIX_MAX,
                     ppp_pkg::PIX_MAX});
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sd1}, 1, 1, ppp_pkg::PIX_MIN,
                     ppp_pkg::PIX_MIN});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff}, 0, 0, 16'd0, 16'd0});
    rows.push_back('{'{16'sh8000, 16'sh7fff, 16'sh8000}, 0, 0, 16'd0, 16'd0});
    rows.push_back('{'{16'sd256, -16'sd256, 16'sd512}, 0, 0, 16'd0, 16'd0});
    rows.push_back('{'{-16'sd1, 16'sd1, 16'sd1}, 0, 0, 16'd0, 16'd0});
    foreach (rows[i]) begin
      if (rows[i].check_fixed) begin
        if (project_point(rows[i].pt, px) != rows[i].kept ||
            (rows[i].kept && px !== ppp_pkg::pixel_t'({rows[i].v, rows[i].u}))) begin
          $error("directed row %0d disagrees with its typed result", i);
          errors++;
        end
      end
      send_point(rows[i].pt);
    end
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      if (phase == 7) begin
        write_reg(ppp_pkg::REG_ROT_ROW_0, 64'hffff_ffff_ffff_ffff);
        write_reg(ppp_pkg::REG_ROT_ROW_1, 64'h0000_8000_8000_8000);
        write_reg(ppp_pkg::REG_ROT_ROW_2, 64'h0000_7fff_7fff_7fff);
        write_reg(ppp_pkg::REG_TRANSLATION, 64'hffff_8000_7fff_8000);
        write_reg(ppp_pkg::REG_FOCAL_X, 64'hfff);
        write_reg(ppp_pkg::REG_FOCAL_Y, 64'h0);
        write_reg(ppp_pkg::REG_CENTER_X, 64'hfff);
        write_reg(ppp_pkg::REG_CENTER_Y, 64'h0);
      end else if (phase > 0) begin
        write_reg(ppp_pkg::REG_ROT_ROW_0, 64'(rand_rot()));
        write_reg(ppp_pkg::REG_ROT_ROW_1, 64'(rand_rot()));
        write_reg(ppp_pkg::REG_ROT_ROW_2,
                  64'({2'b00, 14'($urandom), 32'(rand_rot())}));
        write_reg(ppp_pkg::REG_TRANSLATION,
                  64'({$urandom_range(1) ? 16'h0400 : 16'($urandom), 32'($urandom)}));
        write_reg(ppp_pkg::REG_FOCAL_X, 64'($urandom_range(4095)));
        write_reg(ppp_pkg::REG_FOCAL_Y, 64'($urandom_range(4095)));
        write_reg(ppp_pkg::REG_CENTER_X, 64'($urandom_range(4095)));
        write_reg(ppp_pkg::REG_CENTER_Y, 64'($urandom_range(4095)));
      end
      repeat (100) begin
        p.world_x = rand_coord();
        p.world_y = rand_coord();
        p.world_z = ($urandom_range(3) == 0) ? rand_coord() : 16'($urandom_range(32767, 1));
        send_point(p);
      end
      drain();
    end

    $display("Sent %0d points through eight register settings and four idling mixes;",
             points_sent);
    $display("%0d pixels were compared, %0d mismatches.", pixels_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
